/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: always");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`endif

/* rtl/core/pbs_pkg.sv */
// Package for the HSV value adjust block: widths, Q16 constants, pipeline latency.
// No dependencies.
package pbs_pkg;

    localparam int FRAC     = 16;
    localparam int DIV_QW   = FRAC + 3;
    localparam int PIPE_LAT = DIV_QW + 5;

    localparam logic [FRAC:0] Q16_ONE = {1'b1, {FRAC{1'b0}}};
    localparam logic [7:0]    ALPHA_OPAQUE = 8'hFF;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    typedef struct packed {
        logic       gray;
        logic [7:0] lvl;
        logic [7:0] alpha;
    } side_t;

endpackage

/* rtl/core/pbs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, 8-bit divisor.
// Depends on pbs_pkg.
module pbs_div
    import pbs_pkg::*;
(
    input  logic              clk,
    input  logic [7:0]        rem_in,
    input  logic [DIV_QW-1:0] num_in,
    input  logic [7:0]        den_in,
    output logic [DIV_QW-1:0] quot
);

    logic [7:0]        rem_reg  [DIV_QW];
    logic [DIV_QW-1:0] num_reg  [DIV_QW];
    logic [7:0]        den_reg  [DIV_QW];
    logic [DIV_QW-1:0] quot_reg [DIV_QW];

    logic [7:0]        rem_s  [DIV_QW];
    logic [DIV_QW-1:0] num_s  [DIV_QW];
    logic [7:0]        den_s  [DIV_QW];
    logic [DIV_QW-1:0] quot_s [DIV_QW];
    logic [8:0]        trial  [DIV_QW];
    logic              ge     [DIV_QW];

    always_comb
    begin
        for (int i = 0; i < DIV_QW; i++)
        begin
            if (i == 0)
            begin
                rem_s[i]  = rem_in;
                num_s[i]  = num_in;
                den_s[i]  = den_in;
                quot_s[i] = '0;
            end
            else
            begin
                rem_s[i]  = rem_reg[i-1];
                num_s[i]  = num_reg[i-1];
                den_s[i]  = den_reg[i-1];
                quot_s[i] = quot_reg[i-1];
            end
            trial[i] = {rem_s[i], num_s[i][DIV_QW-1]};
            ge[i]    = trial[i] >= {1'b0, den_s[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_QW; i++)
        begin
            if (ge[i])
                rem_reg[i] <= 8'(trial[i] - {1'b0, den_s[i]});
            else
                rem_reg[i] <= trial[i][7:0];
            num_reg[i]  <= {num_s[i][DIV_QW-2:0], 1'b0};
            den_reg[i]  <= den_s[i];
            quot_reg[i] <= {quot_s[i][DIV_QW-2:0], ge[i]};
        end
    end

    assign quot = quot_reg[DIV_QW-1];

endmodule

/* rtl/core/pixel_brightness_set_hsv.sv */
// HSV value adjust of one ARGB pixel per clock, fixed point Q16 hue and saturation.
// Depends on pbs_pkg and pbs_div.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+--------------------------
//  command   | pixel_in, level, relative, keep_alpha     | start high, busy low
//  result    | pixel_out                                 | done strobe, one cycle
//
// One pixel per clock; from accept to done it passes two front stages, 19
// divider stages and three back stages. busy is always low: the pipeline never
// stalls, as the receiver takes every result. Reset clears the valid bits only.
module pixel_brightness_set_hsv
    import pbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       pixel_in,
    input  logic signed [8:0] level,
    input  logic              relative,
    input  logic              keep_alpha,
    output logic              done,
    output logic [31:0]       pixel_out
);

    logic [7:0] r_in, g_in, b_in, mx_in, mn_in, lvl_in;
    logic signed [10:0] sum_in, tgt_in;

    logic       vld_a_reg;
    logic [7:0] r_a_reg, g_a_reg, b_a_reg, mx_a_reg, d_a_reg, lvl_a_reg, alpha_a_reg;

    logic signed [11:0] h_s;
    logic signed [11:0] d_x;
    logic        vld_b_reg;
    side_t       side_b_reg;
    logic [10:0] h_b_reg;
    logic [7:0]  d_b_reg, mx_b_reg;

    logic [DIV_QW-1:0] vld_s_reg;
    side_t side_reg [DIV_QW];
    logic [DIV_QW-1:0] hue_q, sat_q;

    logic [FRAC-1:0] fr_c;
    logic [FRAC:0]   s_c, inv_fr;
    logic [32:0]     prod_q;
    logic [33:0]     prod_t;

    logic        vld_c_reg;
    side_t       side_c_reg;
    logic [2:0]  sec_c_reg;
    logic [FRAC:0] s_c_reg, sf_c_reg, sif_c_reg;

    logic [FRAC:0] p_d, q_d, t_d;
    logic [FRAC:0] fr_next, fg_next, fb_next;
    logic        vld_d_reg;
    side_t       side_d_reg;
    logic [FRAC:0] fr_d_reg, fg_d_reg, fb_d_reg;

    logic [24:0] pr_e, pg_e, pb_e;
    logic        done_reg;
    logic [31:0] pixel_out_reg;

    assign busy = 1'b0;

    // stage A: max, min, target level
    always_comb
    begin
        r_in  = pixel_in[23:16];
        g_in  = pixel_in[15:8];
        b_in  = pixel_in[7:0];
        mx_in = (r_in > g_in) ? ((r_in > b_in) ? r_in : b_in) : ((g_in > b_in) ? g_in : b_in);
        mn_in = (r_in < g_in) ? ((r_in < b_in) ? r_in : b_in) : ((g_in < b_in) ? g_in : b_in);
        sum_in = $signed({3'b000, mx_in}) + 11'(level);
        tgt_in = relative ? sum_in : 11'(level);
        if (tgt_in < 0)
            lvl_in = 8'd0;
        else if (tgt_in > 11'sd255)
            lvl_in = 8'd255;
        else
            lvl_in = tgt_in[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_a_reg <= 1'b0;
        else
            vld_a_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        r_a_reg     <= r_in;
        g_a_reg     <= g_in;
        b_a_reg     <= b_in;
        mx_a_reg    <= mx_in;
        d_a_reg     <= mx_in - mn_in;
        lvl_a_reg   <= lvl_in;
        alpha_a_reg <= keep_alpha ? pixel_in[31:24] : ALPHA_OPAQUE;
    end

    // stage B: hue numerator in sixths
    always_comb
    begin
        d_x = $signed({4'b0000, d_a_reg});
        priority if (r_a_reg >= mx_a_reg)
            h_s = $signed({4'b0000, g_a_reg}) - $signed({4'b0000, b_a_reg});
        else if (g_a_reg >= mx_a_reg)
            h_s = 12'(2 * d_x) + $signed({4'b0000, b_a_reg}) - $signed({4'b0000, r_a_reg});
        else
            h_s = 12'(4 * d_x) + $signed({4'b0000, r_a_reg}) - $signed({4'b0000, g_a_reg});
        if (h_s < 0)
            h_s = h_s + 12'(6 * d_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_b_reg <= 1'b0;
        else
            vld_b_reg <= vld_a_reg;
    end

    always_ff @(posedge clk)
    begin
        side_b_reg.gray  <= (d_a_reg == 8'd0);
        side_b_reg.lvl   <= lvl_a_reg;
        side_b_reg.alpha <= alpha_a_reg;
        h_b_reg  <= h_s[10:0];
        d_b_reg  <= d_a_reg;
        mx_b_reg <= mx_a_reg;
    end

    // dividers: hue = h * 2^16 / d, saturation = d * 2^16 / max
    pbs_div u_hue_div (
        .clk    (clk),
        .rem_in (h_b_reg[10:3]),
        .num_in ({h_b_reg[2:0], {FRAC{1'b0}}}),
        .den_in (d_b_reg),
        .quot   (hue_q)
    );

    pbs_div u_sat_div (
        .clk    (clk),
        .rem_in ({3'b000, d_b_reg[7:3]}),
        .num_in ({d_b_reg[2:0], {FRAC{1'b0}}}),
        .den_in (mx_b_reg),
        .quot   (sat_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s_reg <= '0;
        else
            vld_s_reg <= {vld_s_reg[DIV_QW-2:0], vld_b_reg};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_b_reg;
        for (int i = 1; i < DIV_QW; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // stage C: S*f and S*(1-f)
    always_comb
    begin
        fr_c   = hue_q[FRAC-1:0];
        s_c    = sat_q[FRAC:0];
        inv_fr = Q16_ONE - {1'b0, fr_c};
        prod_q = s_c * fr_c;
        prod_t = s_c * inv_fr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_c_reg <= 1'b0;
        else
            vld_c_reg <= vld_s_reg[DIV_QW-1];
    end

    always_ff @(posedge clk)
    begin
        side_c_reg <= side_reg[DIV_QW-1];
        sec_c_reg  <= hue_q[DIV_QW-1:FRAC];
        s_c_reg    <= s_c;
        sf_c_reg   <= prod_q[32:FRAC];
        sif_c_reg  <= prod_t[32:FRAC];
    end

    // stage D: p, q, t and sector select
    always_comb
    begin
        p_d = Q16_ONE - s_c_reg;
        q_d = Q16_ONE - sf_c_reg;
        t_d = Q16_ONE - sif_c_reg;
        unique case (sec_c_reg)
            SEC_0:
            begin
                fr_next = Q16_ONE; fg_next = t_d; fb_next = p_d;
            end
            SEC_1:
            begin
                fr_next = q_d; fg_next = Q16_ONE; fb_next = p_d;
            end
            SEC_2:
            begin
                fr_next = p_d; fg_next = Q16_ONE; fb_next = t_d;
            end
            SEC_3:
            begin
                fr_next = p_d; fg_next = q_d; fb_next = Q16_ONE;
            end
            SEC_4:
            begin
                fr_next = t_d; fg_next = p_d; fb_next = Q16_ONE;
            end
            default:
            begin
                fr_next = Q16_ONE; fg_next = p_d; fb_next = q_d;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_d_reg <= 1'b0;
        else
            vld_d_reg <= vld_c_reg;
    end

    always_ff @(posedge clk)
    begin
        side_d_reg <= side_c_reg;
        fr_d_reg   <= fr_next;
        fg_d_reg   <= fg_next;
        fb_d_reg   <= fb_next;
    end

    // stage E: scale by level, truncate to 8 bits
    always_comb
    begin
        pr_e = side_d_reg.lvl * fr_d_reg;
        pg_e = side_d_reg.lvl * fg_d_reg;
        pb_e = side_d_reg.lvl * fb_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (side_d_reg.gray)
            pixel_out_reg <= {side_d_reg.alpha, side_d_reg.lvl, side_d_reg.lvl, side_d_reg.lvl};
        else
            pixel_out_reg <= {side_d_reg.alpha, pr_e[23:16], pg_e[23:16], pb_e[23:16]};
    end

    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;

endmodule

/* rtl/core/pbs_checker.sv */
// Port-level checker for pixel_brightness_set_hsv, bound to the top level.
// Depends on pbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbs_checker
    import pbs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [31:0]       pixel_in,
    input logic              keep_alpha,
    input logic              done,
    input logic [31:0]       pixel_out
);

    logic opaque_req, gray_req;

    assign opaque_req = start && !keep_alpha;
    assign gray_req   = start && (pixel_in[23:16] == pixel_in[15:8])
                        && (pixel_in[15:8] == pixel_in[7:0]);

    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `ASSERT_IMPLY(a_done_has_cmd, clk, rst_n, done, $past(start, PIPE_LAT))
    `ASSERT_IMPLY(a_alpha_forced, clk, rst_n, done && $past(opaque_req, PIPE_LAT),
        pixel_out[31:24] == ALPHA_OPAQUE)
    `ASSERT_IMPLY(a_gray_equal, clk, rst_n, done && $past(gray_req, PIPE_LAT),
        (pixel_out[23:16] == pixel_out[15:8]) && (pixel_out[15:8] == pixel_out[7:0]))

endmodule

bind pixel_brightness_set_hsv pbs_checker u_pbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .pixel_in   (pixel_in),
    .keep_alpha (keep_alpha),
    .done       (done),
    .pixel_out  (pixel_out)
);

/* tb/testbench.sv */
// Testbench for pixel_brightness_set_hsv: HSV value adjust of ARGB pixels.
// Holds a scoreboard class with its own fixed-point predictor; depends on the block's RTL.
`timescale 1ns / 100ps

class brightness_scoreboard;
    logic [31:0] pending_pixels[$];
    int          mismatches;

    function new();
        mismatches = 0;
    endfunction

    function automatic logic [31:0] predict_pixel(logic [31:0] pix, logic signed [8:0] lv,
                                                  logic rel, logic keep);
        int r, g, b, mx, mn, d, h, tgt;
        longint unsigned hq, sec, fr, s, p, q, t, fa, fg, fb;
        logic [7:0] ro, go, bo, a;
        r = int'(pix[23:16]);
        g = int'(pix[15:8]);
        b = int'(pix[7:0]);
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        d = mx - mn;
        tgt = rel ? mx + int'(lv) : int'(lv);
        if (tgt < 0) tgt = 0;
        if (tgt > 255) tgt = 255;
        if (d == 0)
        begin
            ro = 8'(tgt);
            go = 8'(tgt);
            bo = 8'(tgt);
        end
        else
        begin
            if (r >= mx) h = g - b;
            else if (g >= mx) h = 2 * d + (b - r);
            else h = 4 * d + (r - g);
            if (h < 0) h += 6 * d;
            hq = (longint'(h) << 16) / d;
            sec = hq >> 16;
            fr = hq & 64'hFFFF;
            s = (longint'(d) << 16) / mx;
            p = 65536 - s;
            q = 65536 - ((s * fr) >> 16);
            t = 65536 - ((s * (65536 - fr)) >> 16);
            case (sec)
                0: begin fa = 65536; fg = t; fb = p; end
                1: begin fa = q; fg = 65536; fb = p; end
                2: begin fa = p; fg = 65536; fb = t; end
                3: begin fa = p; fg = q; fb = 65536; end
                4: begin fa = t; fg = p; fb = 65536; end
                default: begin fa = 65536; fg = p; fb = q; end
            endcase
            ro = 8'((tgt * fa) >> 16);
            go = 8'((tgt * fg) >> 16);
            bo = 8'((tgt * fb) >> 16);
        end
        a = keep ? pix[31:24] : 8'hFF;
        return {a, ro, go, bo};
    endfunction

    function void note_pixel(logic [31:0] pix, logic signed [8:0] lv, logic rel, logic keep);
        pending_pixels.push_back(predict_pixel(pix, lv, rel, keep));
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task check_pixel(logic [31:0] got);
        logic [31:0] exp_pix;
        if (pending_pixels.size() == 0)
        begin
            report($sformatf("unexpected result %08h", got));
            return;
        end
        exp_pix = pending_pixels.pop_front();
        if (got !== exp_pix)
            report($sformatf("pixel_out %08h, expected %08h", got, exp_pix));
    endtask
endclass

module testbench;
    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [31:0]       pixel_in;
    logic signed [8:0] level;
    logic              relative;
    logic              keep_alpha;
    logic              done;
    logic [31:0]       pixel_out;

    brightness_scoreboard sb;
    bit quiet_stretch;

    pixel_brightness_set_hsv uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_in(pixel_in), .level(level), .relative(relative),
        .keep_alpha(keep_alpha), .done(done), .pixel_out(pixel_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_pixel(pixel_out);
            if (start && !busy)
                sb.note_pixel(pixel_in, level, relative, keep_alpha);
        end
    end

    // one transaction; random idle cycles beforehand unless in the quiet stretch
    task automatic send_pixel(logic [31:0] pix, logic signed [8:0] lv, logic rel, logic keep);
        while (!quiet_stretch && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        pixel_in   <= pix;
        level      <= lv;
        relative   <= rel;
        keep_alpha <= keep;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        logic [31:0] pix;
        logic [8:0]  lv;
        sb = new();
        quiet_stretch = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel_in = '0;
        level = '0;
        relative = 1'b0;
        keep_alpha = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(32'h00000000, 9'sd0, 1'b0, 1'b0);
        send_pixel(32'hFFFFFFFF, 9'sd255, 1'b0, 1'b1);
        send_pixel(32'h12808080, 9'sd100, 1'b0, 1'b1);
        send_pixel(32'hAAFF0000, 9'sd255, 1'b0, 1'b1);
        send_pixel(32'h5500FF00, 9'sd200, 1'b0, 1'b0);
        send_pixel(32'h550000FF, 9'sd128, 1'b1, 1'b1);
        send_pixel(32'h00FFFF00, 9'sd255, 1'b0, 1'b1);
        send_pixel(32'h0000FFFF, 9'sd255, 1'b0, 1'b1);
        send_pixel(32'h00FF00FF, 9'sd255, 1'b0, 1'b1);
        send_pixel(32'h80FF0001, 9'sd255, 1'b0, 1'b1);
        send_pixel(32'h80FF8000, 9'sd77, 1'b0, 1'b1);
        send_pixel(32'h01102030, -9'sd255, 1'b0, 1'b1);
        send_pixel(32'h01102030, 9'h100, 1'b0, 1'b1);
        send_pixel(32'h01102030, 9'h100, 1'b1, 1'b1);
        send_pixel(32'h01F02030, 9'sd255, 1'b1, 1'b0);
        send_pixel(32'h01F02030, -9'sd255, 1'b1, 1'b1);
        send_pixel(32'hFE010203, 9'sd1, 1'b1, 1'b1);
        send_pixel(32'h7FFEFF01, -9'sd1, 1'b1, 1'b0);
        send_pixel(32'h00010000, 9'sd255, 1'b0, 1'b1);
        send_pixel(32'h00000001, 9'sd255, 1'b1, 1'b1);
        drain();

        for (int i = 0; i < 1300; i++)
        begin
            quiet_stretch = (i >= 400 && i < 600);
            pix = {8'($urandom_range(255)), rand_chan(), rand_chan(), rand_chan()};
            if ($urandom_range(9) == 0)
                pix[15:0] = {pix[23:16], pix[23:16]};
            lv = 9'($urandom_range(511));
            send_pixel(pix, lv, 1'($urandom_range(1)), 1'($urandom_range(1)));
            if (i == 800)
                drain();
        end
        drain();

        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
